>>> rtl/core/rtpe_pkg.sv
// Shared constants, register codes and helper functions of the torus patch evaluator.
package rtpe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PARAM_BITS = 16;
  localparam int ANGLE_BITS = 27;
  localparam int OUT_W      = 26;
  localparam int PAR_W      = PARAM_BITS + 1;
  localparam int RAD_W      = 8;

  // divider geometry: N = t*t + s*s, quotient at most 2^ANGLE_BITS
  localparam int N_W    = 2 * PARAM_BITS + 1;
  localparam int Q_W    = ANGLE_BITS + 1;
  localparam int NUM_W  = N_W + Q_W;
  localparam int COS_SH = PARAM_BITS + ANGLE_BITS;
  localparam int SIN_SH = ANGLE_BITS + 1;

  // combine stage
  localparam int M_W      = RAD_W + ANGLE_BITS + 2;
  localparam int MAG_W    = M_W - 1;
  localparam int SPLIT    = MAG_W / 2;
  localparam int PP_W     = (MAG_W - SPLIT) + Q_W;
  localparam int ZP_W     = RAD_W + Q_W;
  localparam int SHIFT_XY = 2 * ANGLE_BITS - FRAC_BITS;
  localparam int SHIFT_Z  = ANGLE_BITS - FRAC_BITS;

  // pipeline depth
  localparam int FRONT_ST = 3;
  localparam int DIV_ST   = Q_W;
  localparam int SIDE_LEN = FRONT_ST + DIV_ST;
  localparam int VLD_LEN  = SIDE_LEN + 2;

  // configuration port
  localparam int APB_AW = 3;
  localparam logic REG_MAJOR = 1'b0;
  localparam logic REG_MINOR = 1'b1;
  localparam logic [RAD_W-1:0] MAJOR_RST = 8'd5;
  localparam logic [RAD_W-1:0] MINOR_RST = 8'd2;

  // side data that travels with an item: sign of the u and v cosines, quadrant
  typedef struct packed {
    logic       neg_u;
    logic       neg_v;
    logic [1:0] quad;
  } side_t;

  // apply sign to a magnitude and clip to the signed output range
  function automatic logic signed [OUT_W-1:0] sat_coord(input logic [63:0] mag,
                                                         input logic neg);
    logic signed [OUT_W-1:0] res;
    res = OUT_W'(mag);
    if (neg) begin
      if (mag > (64'd1 << (OUT_W - 1))) res = {1'b1, {(OUT_W-1){1'b0}}};
      else res = OUT_W'(~mag + 64'd1);
    end else begin
      if (mag > ((64'd1 << (OUT_W - 1)) - 64'd1)) res = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rtpe_if.sv
// Stream interfaces of the torus patch evaluator: parameter input and point output.
interface rtpe_in_if;
  import rtpe_pkg::*;
  logic             valid;
  logic             ready;
  logic [PAR_W-1:0] u_param;
  logic [PAR_W-1:0] v_param;
  logic [1:0]       quadrant;
  modport source (output valid, u_param, v_param, quadrant, input ready);
  modport sink (input valid, u_param, v_param, quadrant, output ready);
endinterface

interface rtpe_out_if;
  import rtpe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_coord;
  logic signed [OUT_W-1:0] y_coord;
  logic signed [OUT_W-1:0] z_coord;
  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

>>> rtl/core/rtpe_front.sv
// Front stages for one parameter: clamp, squares, divider numerators and denominator.
module rtpe_front (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rtpe_pkg::PAR_W-1:0] p_i,
  output logic [rtpe_pkg::N_W-1:0]   n_o,
  output logic [rtpe_pkg::NUM_W-1:0] acos_o,
  output logic [rtpe_pkg::NUM_W-1:0] asin_o
);
  import rtpe_pkg::*;

  localparam logic [PAR_W-1:0] ONE = PAR_W'(1) << PARAM_BITS;

  logic [PAR_W-1:0]   t_d, t_q, s_q, diff_q, diff2_q;
  logic [N_W-1:0]     tt_q, ss_q;
  logic [N_W-1:0]     ts_q;
  logic [N_W-1:0]     n_d;
  logic [NUM_W-1:0]   acos_q, asin_q;

  assign t_d = (p_i > ONE) ? ONE : p_i;

  // stage 1: clamp and split into t and s
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      s_q    <= ONE - t_d;
      diff_q <= (t_d < (ONE - t_d)) ? (ONE - t_d) - t_d : t_d - (ONE - t_d);
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tt_q    <= N_W'(t_q * t_q);
      ss_q    <= N_W'(s_q * s_q);
      ts_q    <= N_W'(t_q * s_q);
      diff2_q <= diff_q;
    end
  end

  // stage 3: denominator and rounded numerators
  assign n_d = tt_q + ss_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acos_q <= (NUM_W'(diff2_q) << COS_SH) + NUM_W'(n_d >> 1);
      asin_q <= (NUM_W'(ts_q) << SIN_SH) + NUM_W'(n_d >> 1);
    end
  end

  // n travels one stage with the numerators
  logic [N_W-1:0] n_q;
  always_ff @(posedge clk_i) begin
    if (en_i) n_q <= n_d;
  end

  assign n_o    = n_q;
  assign acos_o = acos_q;
  assign asin_o = asin_q;

endmodule

>>> rtl/core/rtpe_div.sv
// Pipelined restoring divider, one quotient bit per stage, for a cosine/sine pair.
module rtpe_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rtpe_pkg::N_W-1:0]   n_i,
  input  logic [rtpe_pkg::NUM_W-1:0] acos_i,
  input  logic [rtpe_pkg::NUM_W-1:0] asin_i,
  output logic [rtpe_pkg::Q_W-1:0]   qcos_o,
  output logic [rtpe_pkg::Q_W-1:0]   qsin_o
);
  import rtpe_pkg::*;

  logic [N_W-1:0] n_q   [DIV_ST];
  logic [N_W-1:0] remc_q [DIV_ST];
  logic [N_W-1:0] rems_q [DIV_ST];
  logic [Q_W-1:0] lowc_q [DIV_ST];
  logic [Q_W-1:0] lows_q [DIV_ST];
  logic [Q_W-1:0] quoc_q [DIV_ST];
  logic [Q_W-1:0] quos_q [DIV_ST];

  for (genvar k = 0; k < DIV_ST; k++) begin : g_st
    logic [N_W-1:0] n_in, remc_in, rems_in;
    logic [Q_W-1:0] lowc_in, lows_in, quoc_in, quos_in;
    logic [N_W:0]   rc, rs;
    logic           gc, gs;

    if (k == 0) begin : g_first
      assign n_in    = n_i;
      assign remc_in = acos_i[NUM_W-1:Q_W];
      assign rems_in = asin_i[NUM_W-1:Q_W];
      assign lowc_in = acos_i[Q_W-1:0];
      assign lows_in = asin_i[Q_W-1:0];
      assign quoc_in = '0;
      assign quos_in = '0;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign remc_in = remc_q[k-1];
      assign rems_in = rems_q[k-1];
      assign lowc_in = lowc_q[k-1];
      assign lows_in = lows_q[k-1];
      assign quoc_in = quoc_q[k-1];
      assign quos_in = quos_q[k-1];
    end

    // shift in the next numerator bit and trial-subtract
    assign rc = {remc_in, lowc_in[Q_W-1]};
    assign rs = {rems_in, lows_in[Q_W-1]};
    assign gc = rc >= {1'b0, n_in};
    assign gs = rs >= {1'b0, n_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_in;
        remc_q[k] <= gc ? N_W'(rc - {1'b0, n_in}) : N_W'(rc);
        rems_q[k] <= gs ? N_W'(rs - {1'b0, n_in}) : N_W'(rs);
        lowc_q[k] <= lowc_in << 1;
        lows_q[k] <= lows_in << 1;
        quoc_q[k] <= {quoc_in[Q_W-2:0], gc};
        quos_q[k] <= {quos_in[Q_W-2:0], gs};
      end
    end
  end

  assign qcos_o = quoc_q[DIV_ST-1];
  assign qsin_o = quos_q[DIV_ST-1];

endmodule

>>> rtl/core/rtpe_back.sv
// Back stages: tube offset, split products, rounding, sign and saturation.
module rtpe_back (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rtpe_pkg::RAD_W-1:0]     major_i,
  input  logic [rtpe_pkg::RAD_W-1:0]     minor_i,
  input  logic [rtpe_pkg::Q_W-1:0]       cu_i,
  input  logic [rtpe_pkg::Q_W-1:0]       su_i,
  input  logic [rtpe_pkg::Q_W-1:0]       cv_i,
  input  logic [rtpe_pkg::Q_W-1:0]       sv_i,
  input  rtpe_pkg::side_t                side_i,
  output logic signed [rtpe_pkg::OUT_W-1:0] x_o,
  output logic signed [rtpe_pkg::OUT_W-1:0] y_o,
  output logic signed [rtpe_pkg::OUT_W-1:0] z_o
);
  import rtpe_pkg::*;

  logic signed [Q_W:0]   cv_s;
  logic signed [M_W-1:0] m_d, m_q;
  logic [ZP_W-1:0]       zp_q;
  logic [Q_W-1:0]        cu_q, su_q;
  side_t                 side_q, side2_q;
  logic [MAG_W-1:0]      mmag;
  logic [PP_W-1:0]       pxh_q, pxl_q, pyh_q, pyl_q;
  logic                  xneg_q, yneg_q;
  logic [ZP_W-1:0]       zmag_q;
  logic [63:0]           xfull, yfull;

  // stage D: M = R*2^27 + r*cos(v), z product
  assign cv_s = side_i.neg_v ? -$signed({1'b0, cv_i}) : $signed({1'b0, cv_i});
  assign m_d  = $signed({2'b0, major_i, {ANGLE_BITS{1'b0}}})
              + M_W'($signed({1'b0, minor_i}) * cv_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      zp_q   <= ZP_W'(minor_i * sv_i);
      cu_q   <= cu_i;
      su_q   <= su_i;
      side_q <= side_i;
    end
  end

  // stage E: magnitude of M split in two halves for narrow multipliers
  assign mmag = m_q[M_W-1] ? MAG_W'(-m_q) : MAG_W'(m_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxh_q   <= PP_W'(mmag[MAG_W-1:SPLIT] * cu_q);
      pxl_q   <= PP_W'(mmag[SPLIT-1:0] * cu_q);
      pyh_q   <= PP_W'(mmag[MAG_W-1:SPLIT] * su_q);
      pyl_q   <= PP_W'(mmag[SPLIT-1:0] * su_q);
      xneg_q  <= m_q[M_W-1] ^ side_q.neg_u;
      yneg_q  <= m_q[M_W-1] ^ side_q.quad[0];
      zmag_q  <= ZP_W'((zp_q + (ZP_W'(1) << (SHIFT_Z - 1))) >> SHIFT_Z);
      side2_q <= side_q;
    end
  end

  // stage F: merge partial products, round, sign and clip
  assign xfull = ((64'(pxh_q) << SPLIT) + 64'(pxl_q) + (64'd1 << (SHIFT_XY - 1))) >> SHIFT_XY;
  assign yfull = ((64'(pyh_q) << SPLIT) + 64'(pyl_q) + (64'd1 << (SHIFT_XY - 1))) >> SHIFT_XY;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= sat_coord(xfull, xneg_q);
      y_o <= sat_coord(yfull, yneg_q);
      z_o <= sat_coord(64'(zmag_q), side2_q.quad[1]);
    end
  end

endmodule

>>> rtl/core/rational_torus_patch_evaluator_top.sv
// Top level of the rational torus patch evaluator.
// Usage:
//   in_i carries u_param, v_param (unsigned, 65536 = 1.0) and quadrant; out_o
//   carries x_coord, y_coord, z_coord as signed Q9.16 points. Each channel is a
//   valid/ready pair; a transfer happens on a clock edge where both are high.
//   The APB port holds major_radius at address 0 and minor_radius at address 4;
//   write them only while no item is in flight.
// Timing:
//   One item per cycle while out_o is not stalled. A result passes through
//   3 front stages (clamp, squares, numerators), 28 divider stages
//   (one quotient bit each, which sets the depth), 2 combine stages and the
//   output register.
// Reset:
//   rst_ni clears all valid bits and loads the radii with 5 and 2.
// Stall:
//   While out_o holds a result that is not taken, the whole pipeline freezes
//   and in_i.ready drops; nothing is lost or repeated. Empty stages still
//   accept while the output is free.
module rational_torus_patch_evaluator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rtpe_in_if.sink                       in_i,
  rtpe_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtpe_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rtpe_pkg::*;

  logic [RAD_W-1:0] major_q, minor_q;
  logic             en, wr;
  logic             vld_q [VLD_LEN];
  side_t            side_q [SIDE_LEN];
  side_t            side_d;
  logic             out_valid_q;

  logic [N_W-1:0]   nu, nv;
  logic [NUM_W-1:0] acu, asu, acv, asv;
  logic [Q_W-1:0]   cu, su, cv, sv;

  // configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= MAJOR_RST;
      minor_q <= MINOR_RST;
    end else if (wr) begin
      if (paddr[2] == REG_MAJOR) major_q <= pwdata[RAD_W-1:0];
      else minor_q <= pwdata[RAD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MINOR) ? 32'(minor_q) : 32'(major_q);

  // global advance: hold every stage while the output waits
  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VLD_LEN; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i < VLD_LEN; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[VLD_LEN-1];
    end
  end

  // cosine sign is t < s, i.e. parameter below one half
  assign side_d.neg_u = ~|in_i.u_param[PAR_W-1:PARAM_BITS-1];
  assign side_d.neg_v = ~|in_i.v_param[PAR_W-1:PARAM_BITS-1];
  assign side_d.quad  = in_i.quadrant;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < SIDE_LEN; i++) side_q[i] <= side_q[i-1];
    end
  end

  rtpe_front u_front_u (.clk_i, .en_i(en), .p_i(in_i.u_param), .n_o(nu),
                        .acos_o(acu), .asin_o(asu));
  rtpe_front u_front_v (.clk_i, .en_i(en), .p_i(in_i.v_param), .n_o(nv),
                        .acos_o(acv), .asin_o(asv));

  rtpe_div u_div_u (.clk_i, .en_i(en), .n_i(nu), .acos_i(acu), .asin_i(asu),
                    .qcos_o(cu), .qsin_o(su));
  rtpe_div u_div_v (.clk_i, .en_i(en), .n_i(nv), .acos_i(acv), .asin_i(asv),
                    .qcos_o(cv), .qsin_o(sv));

  rtpe_back u_back (
    .clk_i,
    .en_i    (en),
    .major_i (major_q),
    .minor_i (minor_q),
    .cu_i    (cu),
    .su_i    (su),
    .cv_i    (cv),
    .sv_i    (sv),
    .side_i  (side_q[SIDE_LEN-1]),
    .x_o     (out_o.x_coord),
    .y_o     (out_o.y_coord),
    .z_o     (out_o.z_coord)
  );

  assign out_o.valid = out_valid_q;

  // a stalled pipeline keeps its first and last valid bits
  a_hold_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(vld_q[0]) && $stable(vld_q[VLD_LEN-1])))
    else $error("valid bits moved during a stall");

  // an item at the last stage reaches the output register
  a_reach_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[VLD_LEN-1] |=> out_valid_q)
    else $error("item lost before the output register");

  // an unaccepted result stays presented
  a_out_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_o.x_coord)
      && $stable(out_o.y_coord) && $stable(out_o.z_coord))
    else $error("result dropped while stalled");

  // a register write to the major radius lands in that radius
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && (paddr[2] == REG_MAJOR) |=> major_q == $past(pwdata[RAD_W-1:0]))
    else $error("major radius write lost");

endmodule
